>>> hw/rtl/slir_pkg.sv
// Shared constants, codes and types for the sorted list block.
package slir_pkg;

  localparam int CAPACITY      = 16;
  localparam int KEY_W         = 32;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int COUNT_FIELD_W = 5;
  localparam int STATUS_W      = 2;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  // Broadcast to every cell for the transaction in flight.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
    key_t key;
  } cmd_t;

  // Chain signals passed from each cell to the next higher one.
  typedef struct packed {
    logic after;  // this cell's key sorts after the new key (or cell is free)
    logic seen;   // an equal key sits at or below this cell
  } link_t;

endpackage

>>> hw/rtl/slir_cell.sv
// One list slot: holds a key and shifts it toward a neighbor on insert or remove.
module slir_cell import slir_pkg::*; (
  input  logic  clk,
  input  cmd_t  cmd,
  input  logic  occupied,
  input  key_t  left_key,
  input  key_t  right_key,
  input  link_t link_in,
  output link_t link_out,
  output key_t  key_q
);

  key_t key_next;
  logic after;
  logic match;

  assign after = occupied ? (key_q > cmd.key) : 1'b1;
  assign match = occupied && (key_q == cmd.key);

  assign link_out.after = after;
  assign link_out.seen  = link_in.seen | match;

  always_comb begin
    key_next = key_q;
    if (cmd.ins_en && after) begin
      // first slot past the insert point takes the new key, the rest shift up
      key_next = link_in.after ? left_key : cmd.key;
    end else if (cmd.rem_en && link_out.seen) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
  end

endmodule

>>> hw/rtl/sorted_list_insert_remove.sv
// Sorted list of signed keys with in-order insert and first-match remove.
// Each accepted request's result is registered to the master side the next cycle.
// One request per cycle unless stalled; each cell compares and shifts in parallel.
// The output register frees the input side whenever the result is taken.
// Reset clears the count and output valid; key slots stay undefined until written.
module sorted_list_insert_remove import slir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[31:0]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // status[1:0], count[6:2], empty_res[7]
);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;
  logic             full;
  logic             found;
  cmd_t             cmd;

  logic [STATUS_W-1:0]      status_q;
  logic [STATUS_W-1:0]      status_next;
  logic [COUNT_FIELD_W-1:0] count_q;
  logic                     empty_q;

  link_t link [CAPACITY+1];
  key_t  keys [CAPACITY];

  // Accept while the result slot is empty or being drained this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (cnt == CNT_W'(CAPACITY));

  assign cmd.key    = key_t'(s_tdata);
  assign cmd.ins_en = accept && (s_tuser == FUNC_INSERT) && !full;
  assign cmd.rem_en = accept && (s_tuser == FUNC_REMOVE);

  // Bottom of the chain: nothing sorts after the key, no match seen yet.
  assign link[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      key_t left_key;
      key_t right_key;
      if (gi == 0) begin : g_lo
        assign left_key = keys[gi];
      end else begin : g_lo_n
        assign left_key = keys[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_hi
        assign right_key = keys[gi];
      end else begin : g_hi_n
        assign right_key = keys[gi+1];
      end
      slir_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occupied  (CNT_W'(gi) < cnt),
        .left_key  (left_key),
        .right_key (right_key),
        .link_in   (link[gi]),
        .link_out  (link[gi+1]),
        .key_q     (keys[gi])
      );
    end
  endgenerate

  // Any match anywhere in the occupied slots shows at the top of the chain.
  assign found = link[CAPACITY].seen;

  always_comb begin
    cnt_next    = cnt;
    status_next = ST_DONE;
    if (s_tuser == FUNC_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        cnt_next = cnt + CNT_W'(1);
      end
    end else begin
      if (cnt == '0) begin
        status_next = ST_EMPTY;
      end else if (!found) begin
        status_next = ST_MISSING;
      end else begin
        cnt_next = cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next transaction replaces it.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      count_q  <= COUNT_FIELD_W'(cnt_next);
      empty_q  <= (cnt_next == '0);
    end
  end

  assign m_tdata = {empty_q, count_q, status_q};

endmodule

>>> test/sorted_list_insert_remove_tb.sv
// Testbench for the sorted list: directed and random requests, scoreboard on every result.
module sorted_list_insert_remove_tb;
  import slir_pkg::*;

  // Result fields carried on m_tdata; the struct order is not the bit order on m_tdata.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_FIELD_W-1:0] count;
    logic                     empty_flag;
  } list_result_t;

  // Scoreboard: tracks the list contents and holds the results still owed.
  class sorted_list_tracker;
    key_t         slots[CAPACITY];
    int unsigned  fill;
    list_result_t pending_results[$];
    int           errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the tracked list and queue its result.
    function void note_request(logic func, key_t key);
      list_result_t res;
      int unsigned  pos;
      res.status = ST_DONE;
      pos = 0;
      if (func == FUNC_INSERT) begin
        if (fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // skip smaller and equal keys: the new key lands after its duplicates
          while (pos < fill && slots[pos] <= key) pos++;
          for (int unsigned j = fill; j > pos; j--) slots[j] = slots[j-1];
          slots[pos] = key;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          while (pos < fill && slots[pos] != key) pos++;
          if (pos >= fill) begin
            res.status = ST_MISSING;
          end else begin
            for (int unsigned j = pos; j + 1 < fill; j++) slots[j] = slots[j+1];
            fill--;
          end
        end
      end
      res.count      = fill[COUNT_FIELD_W-1:0];
      res.empty_flag = (fill == 0);
      pending_results.push_back(res);
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(logic [7:0] data);
      list_result_t want;
      list_result_t got;
      got.status     = data[1:0];
      got.count      = data[6:2];
      got.empty_flag = data[7];
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, got %h", $time, data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.empty_flag !== want.empty_flag) begin
        $display("%0t: empty flag expected %0b actual %0b", $time, want.empty_flag,
                 got.empty_flag);
        errors++;
      end
    endfunction
  endclass

  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_LIMIT     = 3000;
  localparam int RANDOM_ITEMS   = 550;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = FUNC_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  sorted_list_tracker tracker = new();
  int  requests_sent = 0;
  int  idle_cycles = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  next_hold_at = 150;

  sorted_list_insert_remove dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one; none in steady stretches.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request and hold it until the block takes it.
  // Leaves s_tvalid high on return; the next call lowers it only for a gap.
  task automatic send_request(logic func, key_t key);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = func;
    s_tdata  = key;
    do @(posedge clk); while (!s_tready);
    tracker.note_request(func, key);
    requests_sent++;
    @(negedge clk);
  endtask

  // Keys biased toward a small pool so that duplicates and remove hits are common.
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return key_t'($signed($urandom_range(0, 15)) - 8);
    if (r < 60) return {1'b1, 31'd0};
    if (r < 70) return {1'b0, {31{1'b1}}};
    return key_t'($urandom);
  endfunction

  // Removes mostly hit a stored key; the rest probe for absent ones.
  function automatic key_t pick_remove_key();
    if (tracker.fill > 0 && $urandom_range(0, 99) < 70)
      return tracker.slots[$urandom_range(0, tracker.fill - 1)];
    return pick_key();
  endfunction

  task automatic run_directed();
    send_request(FUNC_REMOVE, 32'sd0);           // remove from an empty list
    send_request(FUNC_INSERT, {1'b1, 31'd0});    // most negative key
    send_request(FUNC_INSERT, {1'b0, {31{1'b1}}}); // most positive key
    send_request(FUNC_INSERT, 32'sd0);
    send_request(FUNC_INSERT, -32'sd1);
    send_request(FUNC_INSERT, 32'sd0);           // duplicate goes after the first zero
    send_request(FUNC_REMOVE, 32'sd0);           // drops the first of the duplicates
    send_request(FUNC_REMOVE, 32'sd12345);       // absent key
    // fill the list to capacity, with a few repeated keys on the way
    for (int i = 0; i < CAPACITY - 4; i++)
      send_request(FUNC_INSERT, key_t'((i % 5) * 1000 - 2000));
    send_request(FUNC_INSERT, 32'sd7);           // insert into a full list
    send_request(FUNC_REMOVE, {1'b0, {31{1'b1}}});
    send_request(FUNC_REMOVE, {1'b1, 31'd0});
  endtask

  // Bursts with a shifting insert bias so the count sweeps empty to full and back.
  task automatic run_random();
    int done_n;
    int burst_len;
    int insert_pct;
    done_n = 0;
    while (done_n < RANDOM_ITEMS) begin
      burst_len = $urandom_range(20, 50);
      case ($urandom_range(0, 3))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst_len && done_n < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < insert_pct)
          send_request(FUNC_INSERT, pick_key());
        else
          send_request(FUNC_REMOVE, pick_remove_key());
        done_n++;
      end
    end
  endtask

  // Result side: random stalls, steady stretches, and long hold-offs that
  // back the block up while the sender keeps offering.
  initial begin : result_sink
    int stall_left;
    int steady_left;
    stall_left = 0;
    steady_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (requests_sent >= next_hold_at) begin
        next_hold_at += 250;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (steady_left == 0) begin
        rx_steady = ($urandom_range(0, 3) == 0);
        steady_left = $urandom_range(20, 120);
      end
      steady_left--;
      if (stall_left == 0 && !rx_steady && $urandom_range(0, 99) < 25)
        stall_left = pick_gap(1'b0);
      m_tready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Check every result transaction at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    run_random();
    s_tvalid = 1'b0;
    wait (tracker.pending_results.size() == 0);
    // wait out any stray result before the final check
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
